### rtl/dltq_pkg.sv
// Package for the delta-list timer queue: sizes, command and status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package dltq_pkg;

   localparam int MAX_TIMERS = 16;
   localparam int DELAY_BITS = 32;
   localparam int ID_BITS    = 4;
   localparam int TICK_BITS  = 32;
   localparam int POS_BITS   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_TIMERS + 1);

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_DEL  = 2'd1,
      CMD_QRY  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DUP    = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD_WALK,
      S_DEL_FIND,
      S_QRY_WALK
   } state_type;

   typedef struct packed {
      logic       load;        // capture the request
      logic       add_step;    // subtract current delta, advance
      logic       insert;      // insert new entry at cursor
      logic       find_step;   // advance cursor
      logic       remove;      // unlink entry at cursor
      logic       query_step;  // accumulate current delta, advance
      logic       finish;      // load the response registers
      logic       fin_sum;     // response carries the running sum
      status_type fin_code;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type req_cmd;
      logic    req_in_range;
      logic    req_queued;
      logic    add_continue;
      logic    id_match;
   } dp_stat_type;

endpackage

### rtl/dltq_ctrl.sv
// Controller for the delta-list timer queue: sequences add, delete and query walks.
// Depends on dltq_pkg.
`timescale 1ns / 1ps

module dltq_ctrl import dltq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (stat.req_cmd)
                  CMD_ADD: begin
                     if (stat.req_in_range && !stat.req_queued) state_in = S_ADD_WALK;
                  end
                  CMD_DEL: begin
                     if (stat.req_in_range && stat.req_queued) state_in = S_DEL_FIND;
                  end
                  CMD_QRY: begin
                     if (stat.req_in_range && stat.req_queued) state_in = S_QRY_WALK;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_WALK: begin
            if (!stat.add_continue) state_in = S_IDLE;
         end
         S_DEL_FIND, S_QRY_WALK: begin
            if (stat.id_match) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.fin_code = ST_OK;
      busy     = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (stat.req_cmd)
                  CMD_ADD: begin
                     if (!stat.req_in_range) begin
                        cmd.finish   = 1'b1;
                        cmd.fin_code = ST_ABSENT;
                     end else if (stat.req_queued) begin
                        cmd.finish   = 1'b1;
                        cmd.fin_code = ST_DUP;
                     end
                  end
                  CMD_DEL, CMD_QRY: begin
                     if (!(stat.req_in_range && stat.req_queued)) begin
                        cmd.finish   = 1'b1;
                        cmd.fin_code = ST_ABSENT;
                     end
                  end
                  default: cmd.finish = 1'b1;
               endcase
            end
         end
         S_ADD_WALK: begin
            if (stat.add_continue) begin
               cmd.add_step = 1'b1;
            end else begin
               cmd.insert = 1'b1;
               cmd.finish = 1'b1;
            end
         end
         S_DEL_FIND: begin
            if (stat.id_match) begin
               cmd.remove = 1'b1;
               cmd.finish = 1'b1;
            end else begin
               cmd.find_step = 1'b1;
            end
         end
         S_QRY_WALK: begin
            if (stat.id_match) begin
               cmd.finish  = 1'b1;
               cmd.fin_sum = 1'b1;
            end else begin
               cmd.query_step = 1'b1;
            end
         end
         default: cmd.finish = 1'b0;
      endcase
   end

endmodule

### rtl/dltq_datapath.sv
// Datapath for the delta-list timer queue: entry registers, walk cursor,
// delay accumulator and response registers.
// Depends on dltq_pkg.
`timescale 1ns / 1ps

module dltq_datapath import dltq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_cmd,
   input  logic [ID_BITS-1:0]   req_timer_id,
   input  logic [TICK_BITS-1:0] req_delay_ticks,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   output logic                 rsp_valid,
   output logic [TICK_BITS-1:0] rsp_remaining_ticks,
   output logic [1:0]           rsp_status_code
);

   logic [ID_BITS-1:0]    ids_ff    [MAX_TIMERS];
   logic [ID_BITS-1:0]    ids_in    [MAX_TIMERS];
   logic [DELAY_BITS-1:0] delays_ff [MAX_TIMERS];
   logic [DELAY_BITS-1:0] delays_in [MAX_TIMERS];
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [MAX_TIMERS-1:0] queued_ff, queued_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [DELAY_BITS-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TICK_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]            rsp_code_ff, rsp_code_in;

   logic [ID_BITS-1:0]    rd_id;
   logic [DELAY_BITS-1:0] rd_delay;
   logic [DELAY_BITS-1:0] sum_next;
   logic                  req_in_range;

   assign rd_id    = ids_ff[idx_ff[POS_BITS-1:0]];
   assign rd_delay = delays_ff[idx_ff[POS_BITS-1:0]];
   assign sum_next = acc_ff + rd_delay;
   assign req_in_range = (32'(req_timer_id) < 32'(MAX_TIMERS));

   always_comb begin
      stat.req_cmd      = cmd_type'(req_cmd);
      stat.req_in_range = req_in_range;
      stat.req_queued   = req_in_range && queued_ff[POS_BITS'(req_timer_id)];
      stat.add_continue = (idx_ff < count_ff) && (acc_ff >= rd_delay);
      stat.id_match     = (rd_id == id_ff);
   end

   always_comb begin
      count_in     = count_ff;
      queued_in    = queued_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      acc_in       = acc_ff;
      rsp_valid_in = cmd.finish;
      rsp_value_in = rsp_value_ff;
      rsp_code_in  = rsp_code_ff;

      if (cmd.load) begin
         id_in  = req_timer_id;
         idx_in = '0;
         acc_in = (cmd_type'(req_cmd) == CMD_QRY) ? '0 : DELAY_BITS'(req_delay_ticks);
      end
      if (cmd.add_step) begin
         acc_in = acc_ff - rd_delay;
         idx_in = idx_ff + CNT_BITS'(1);
      end
      if (cmd.find_step) begin
         idx_in = idx_ff + CNT_BITS'(1);
      end
      if (cmd.query_step) begin
         acc_in = sum_next;
         idx_in = idx_ff + CNT_BITS'(1);
      end
      if (cmd.insert) begin
         count_in = count_ff + CNT_BITS'(1);
         queued_in[POS_BITS'(id_ff)] = 1'b1;
      end
      if (cmd.remove) begin
         count_in = count_ff - CNT_BITS'(1);
         queued_in[POS_BITS'(id_ff)] = 1'b0;
      end
      if (cmd.finish) begin
         rsp_value_in = cmd.fin_sum ? TICK_BITS'(sum_next) : '0;
         rsp_code_in  = cmd.fin_code;
      end
   end

   // Every entry looks only at itself and its two neighbors.
   always_comb begin
      for (int k = 0; k < MAX_TIMERS; k++) begin
         ids_in[k]    = ids_ff[k];
         delays_in[k] = delays_ff[k];
         if (cmd.insert) begin
            if (CNT_BITS'(k) == idx_ff) begin
               ids_in[k]    = id_ff;
               delays_in[k] = acc_ff;
            end else if (CNT_BITS'(k) > idx_ff) begin
               ids_in[k] = ids_ff[(k == 0) ? 0 : k - 1];
               // old entry at the cursor loses the new delta
               if (CNT_BITS'(k) == idx_ff + CNT_BITS'(1)) begin
                  delays_in[k] = delays_ff[(k == 0) ? 0 : k - 1] - acc_ff;
               end else begin
                  delays_in[k] = delays_ff[(k == 0) ? 0 : k - 1];
               end
            end
         end
         if (cmd.remove) begin
            if (CNT_BITS'(k) == idx_ff) begin
               // fold removed delta into the right neighbor as it moves down
               ids_in[k]    = ids_ff[(k == MAX_TIMERS - 1) ? k : k + 1];
               delays_in[k] = delays_ff[(k == MAX_TIMERS - 1) ? k : k + 1] + delays_ff[k];
            end else if (CNT_BITS'(k) > idx_ff) begin
               ids_in[k]    = ids_ff[(k == MAX_TIMERS - 1) ? k : k + 1];
               delays_in[k] = delays_ff[(k == MAX_TIMERS - 1) ? k : k + 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      id_ff        <= id_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_code_ff  <= rsp_code_in;
      for (int k = 0; k < MAX_TIMERS; k++) begin
         ids_ff[k]    <= ids_in[k];
         delays_ff[k] <= delays_in[k];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_remaining_ticks = rsp_value_ff;
   assign rsp_status_code     = rsp_code_ff;

endmodule

### rtl/delta_list_timer_queue.sv
// Top level of the delta-list timer queue: controller plus datapath.
// Depends on dltq_pkg, dltq_ctrl and dltq_datapath.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its single response
// appears on the rsp_ ports with rsp_valid high for exactly one cycle and must
// be captured then, since the block cannot be held off. Commands that are
// rejected (duplicate add, absent id) and the unused command code answer in the
// cycle after acceptance, with busy staying low. An add walks the list one
// entry per cycle while entries remain and the stored deltas do not exceed
// the remaining delay, and inserts in the cycle that stops the walk. Delete
// and query scan one entry per cycle up to the matching id. The response
// shows in the cycle after the last busy cycle, and a new command may be
// issued in that same cycle. Throughput is set by the single-cursor list walk.
module delta_list_timer_queue import dltq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_cmd,
   input  logic [ID_BITS-1:0]   req_timer_id,
   input  logic [TICK_BITS-1:0] req_delay_ticks,
   output logic                 rsp_valid,
   output logic [TICK_BITS-1:0] rsp_remaining_ticks,
   output logic [1:0]           rsp_status_code
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   logic        ctrl_busy;

   dltq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (dp_stat),
      .cmd   (dp_cmd),
      .busy  (ctrl_busy)
   );

   dltq_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_cmd),
      .req_timer_id        (req_timer_id),
      .req_delay_ticks     (req_delay_ticks),
      .cmd                 (dp_cmd),
      .stat                (dp_stat),
      .rsp_valid           (rsp_valid),
      .rsp_remaining_ticks (rsp_remaining_ticks),
      .rsp_status_code     (rsp_status_code)
   );

   assign busy = ctrl_busy;

endmodule

### rtl/dltq_checker.sv
// Port-level checks for the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg and delta_list_timer_queue.
`timescale 1ns / 1ps

module dltq_checker import dltq_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [1:0]           req_cmd,
   input logic                 rsp_valid,
   input logic [TICK_BITS-1:0] rsp_remaining_ticks,
   input logic [1:0]           rsp_status_code
);

   // an accepted transaction either keeps the block busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   // a response only follows an accepted or running transaction
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("response without a transaction");

   a_unused_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_NONE) |=>
         (rsp_valid && !busy && rsp_remaining_ticks == '0 && rsp_status_code == ST_OK))
      else $error("unused command answered wrongly");

   a_error_no_ticks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status_code != ST_OK) |->
         (rsp_remaining_ticks == '0 && (rsp_status_code == ST_DUP ||
                                        rsp_status_code == ST_ABSENT)))
      else $error("error response carries ticks or a bad code");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_cmd             (req_cmd),
   .rsp_valid           (rsp_valid),
   .rsp_remaining_ticks (rsp_remaining_ticks),
   .rsp_status_code     (rsp_status_code)
);
